// ===== rtl/core/spo_pkg.sv =====
`timescale 1ns / 1ps
// spo_pkg: beat types, command/status structs and codes for the serpentine
// probe point sequencer. No dependencies.
package spo_pkg;

  localparam int MAX_GRID_DEF = 64;

  localparam int IDX_OUT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 3'd5;

  localparam logic [6:0]  GRID_RST = 7'd2;
  localparam logic [22:0] STEP_RST = 23'd1000;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  // walk phases
  localparam logic [1:0] PH_LINE   = 2'd0;
  localparam logic [1:0] PH_AFTER  = 2'd1;
  localparam logic [1:0] PH_BEFORE = 2'd2;
  localparam logic [1:0] PH_REST   = 2'd3;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] cur_x;
    logic signed [23:0] cur_y;
    logic               scan_by_columns;
  } spo_in_t;

  typedef struct packed {
    logic                 point_valid;
    logic [IDX_OUT_W-1:0] col_index;
    logic [IDX_OUT_W-1:0] row_index;
    logic signed [31:0]   point_x;
    logic signed [31:0]   point_y;
    logic                 last_point;
  } spo_out_t;

  typedef struct packed {
    logic start;
    logic seed;
    logic mul;
    logic emit;
    logic zero;
  } spo_cmd_t;

  typedef struct packed {
    logic active;
    logic div_done;
    logic out_free;
  } spo_sts_t;

endpackage

// ===== rtl/core/spo_div.sv =====
`timescale 1ns / 1ps
// spo_div: nearest grid vertex index, rounding half away from zero, one
// quotient bit per cycle, clamped to the last vertex. Depends on spo_pkg.
module spo_div
  import spo_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [23:0]          cur,
  input  logic signed [23:0]          org,
  input  logic [22:0]                 step,
  input  logic [$clog2(MAX_GRID)-1:0] nmax,
  output logic                        done,
  output logic [$clog2(MAX_GRID)-1:0] q
);

  localparam int IDX_W = $clog2(MAX_GRID);
  localparam int QW    = IDX_W + 1;
  localparam int RW    = 26 + IDX_W;
  localparam int CW    = $clog2(QW + 1);

  logic signed [24:0] diff;
  logic [RW-1:0]      numer;
  logic [RW-1:0]      rem_r, rem_nxt;
  logic [RW-1:0]      dsh_r, dsh_nxt;
  logic [QW-1:0]      quo_r, quo_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               ge;

  always_comb begin
    diff  = {cur[23], cur} - {org[23], org};
    numer = '0;
    if (!diff[24] && diff != '0) begin
      numer = RW'({diff[23:0], 1'b0}) + RW'(step);
    end
    ge      = rem_r >= dsh_r;
    rem_nxt = ge ? rem_r - dsh_r : rem_r;
    dsh_nxt = dsh_r >> 1;
    quo_nxt = {quo_r[QW-2:0], ge};
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(QW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer;
      dsh_r <= RW'({step, 1'b0}) << IDX_W;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = cnt_r == '0;
  assign q    = (quo_r > QW'(nmax)) ? nmax : IDX_W'(quo_r);

endmodule

// ===== rtl/core/spo_walk.sv =====
`timescale 1ns / 1ps
// spo_walk: next step of the serpentine walk, in line-relative terms
// (a along the line, b across lines). Depends on spo_pkg.
module spo_walk
  import spo_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF
) (
  input  logic [$clog2(MAX_GRID)-1:0]   a,
  input  logic [$clog2(MAX_GRID)-1:0]   b,
  input  logic [$clog2(MAX_GRID)-1:0]   sa,
  input  logic [$clog2(MAX_GRID)-1:0]   sb,
  input  logic [$clog2(MAX_GRID+1)-1:0] w,
  input  logic [$clog2(MAX_GRID+1)-1:0] h,
  input  logic [1:0]                    phase,
  input  logic                          fwd,
  output logic [$clog2(MAX_GRID)-1:0]   a_nxt,
  output logic [$clog2(MAX_GRID)-1:0]   b_nxt,
  output logic [1:0]                    phase_nxt,
  output logic                          fwd_nxt,
  output logic                          more
);

  localparam int IDX_W = $clog2(MAX_GRID);
  localparam int CNT_W = $clog2(MAX_GRID + 1);
  localparam int EW    = CNT_W + 1;

  logic [IDX_W-1:0] line_end;
  logic             a_fwd_ok, a_back_ok, rest_fwd_ok;
  logic             go_after, go_before, go_rest;

  always_comb begin
    line_end    = IDX_W'(w - CNT_W'(1));
    a_fwd_ok    = (EW'(a) + EW'(1)) < EW'(w);
    a_back_ok   = a != '0;
    rest_fwd_ok = (EW'(a) + EW'(1)) < EW'(sa);

    a_nxt     = a;
    b_nxt     = b;
    phase_nxt = phase;
    fwd_nxt   = fwd;
    more      = 1'b1;
    go_after  = 1'b0;
    go_before = 1'b0;
    go_rest   = 1'b0;

    case (phase)
      PH_LINE: begin
        if (a_fwd_ok) begin
          a_nxt = a + IDX_W'(1);
        end else begin
          fwd_nxt  = 1'b0;
          go_after = 1'b1;
        end
      end
      PH_AFTER: begin
        if (fwd && a_fwd_ok) begin
          a_nxt = a + IDX_W'(1);
        end else if (!fwd && a_back_ok) begin
          a_nxt = a - IDX_W'(1);
        end else begin
          fwd_nxt = ~fwd;
          if ((EW'(b) + EW'(1)) < EW'(h)) begin
            b_nxt = b + IDX_W'(1);
            a_nxt = fwd_nxt ? '0 : line_end;
          end else begin
            go_before = 1'b1;
          end
        end
      end
      PH_BEFORE: begin
        if (fwd && a_fwd_ok) begin
          a_nxt = a + IDX_W'(1);
        end else if (!fwd && a_back_ok) begin
          a_nxt = a - IDX_W'(1);
        end else begin
          fwd_nxt = ~fwd;
          if (b != '0) begin
            b_nxt = b - IDX_W'(1);
            a_nxt = fwd_nxt ? '0 : line_end;
          end else begin
            go_rest = 1'b1;
          end
        end
      end
      default: begin
        if (fwd && rest_fwd_ok) begin
          a_nxt = a + IDX_W'(1);
        end else if (!fwd && a_back_ok) begin
          a_nxt = a - IDX_W'(1);
        end else begin
          more = 1'b0;
        end
      end
    endcase

    if (go_after) begin
      if ((EW'(sb) + EW'(1)) >= EW'(h)) begin
        go_before = 1'b1;
      end else begin
        phase_nxt = PH_AFTER;
        b_nxt     = sb + IDX_W'(1);
        a_nxt     = fwd_nxt ? '0 : line_end;
      end
    end
    if (go_before) begin
      if (sb == '0) begin
        go_rest = 1'b1;
      end else begin
        phase_nxt = PH_BEFORE;
        b_nxt     = sb - IDX_W'(1);
        a_nxt     = fwd_nxt ? '0 : line_end;
      end
    end
    if (go_rest) begin
      if (sa == '0) begin
        more = 1'b0;
      end else begin
        phase_nxt = PH_REST;
        b_nxt     = sb;
        a_nxt     = fwd_nxt ? '0 : sa - IDX_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/spo_dp.sv =====
`timescale 1ns / 1ps
// spo_dp: configuration registers, scan state, rounding dividers, position
// multiply/saturate and the output register. Depends on spo_pkg, spo_div, spo_walk.
module spo_dp
  import spo_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  spo_in_t               in_data,
  input  spo_cmd_t              cmd,
  output spo_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spo_out_t              out_data
);

  localparam int IDX_W = $clog2(MAX_GRID);
  localparam int CNT_W = $clog2(MAX_GRID + 1);
  localparam int PW    = 23 + IDX_W;
  localparam int SW    = 34;

  logic [6:0]         grid_cols_r, grid_rows_r;
  logic signed [23:0] org_x_r, org_y_r;
  logic [22:0]        step_x_r, step_y_r;

  logic [CNT_W-1:0] nc, nr;
  logic [22:0]      sx, sy;

  logic             active_r, cols_mode_r, fwd_r, out_valid_r;
  logic [1:0]       phase_r;
  logic [IDX_W-1:0] start_col_r, start_row_r, walk_col_r, walk_row_r;
  logic [PW-1:0]    prod_x_r, prod_y_r;
  spo_out_t         out_r, out_nxt;

  logic             x_done, y_done;
  logic [IDX_W-1:0] qx, qy;

  logic [IDX_W-1:0] wa, wb, wsa, wsb, wa_nxt, wb_nxt;
  logic [CNT_W-1:0] ww, wh;
  logic [1:0]       phase_nxt;
  logic             fwd_nxt, more, out_free;

  logic signed [SW-1:0] sum_x, sum_y;

  function automatic logic [CNT_W-1:0] grid_count(input logic [6:0] r);
    logic [CNT_W-1:0] n;
    if (r == '0) begin
      n = CNT_W'(1);
    end else if (32'(r) > MAX_GRID) begin
      n = CNT_W'(MAX_GRID);
    end else begin
      n = CNT_W'(r);
    end
    return n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] s;
    if (!v[SW-1] && v[SW-2:31] != '0) begin
      s = 32'sh7FFF_FFFF;
    end else if (v[SW-1] && v[SW-2:31] != '1) begin
      s = 32'sh8000_0000;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

  assign nc = grid_count(grid_cols_r);
  assign nr = grid_count(grid_rows_r);
  assign sx = (step_x_r == '0) ? 23'd1 : step_x_r;
  assign sy = (step_y_r == '0) ? 23'd1 : step_y_r;

  spo_div #(.MAX_GRID(MAX_GRID)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .cur   (in_data.cur_x),
    .org   (org_x_r),
    .step  (sx),
    .nmax  (IDX_W'(nc - CNT_W'(1))),
    .done  (x_done),
    .q     (qx)
  );

  spo_div #(.MAX_GRID(MAX_GRID)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .cur   (in_data.cur_y),
    .org   (org_y_r),
    .step  (sy),
    .nmax  (IDX_W'(nr - CNT_W'(1))),
    .done  (y_done),
    .q     (qy)
  );

  // line-relative view: rows mode walks along x, columns mode along y
  assign wa  = cols_mode_r ? walk_row_r : walk_col_r;
  assign wb  = cols_mode_r ? walk_col_r : walk_row_r;
  assign wsa = cols_mode_r ? start_row_r : start_col_r;
  assign wsb = cols_mode_r ? start_col_r : start_row_r;
  assign ww  = cols_mode_r ? nr : nc;
  assign wh  = cols_mode_r ? nc : nr;

  spo_walk #(.MAX_GRID(MAX_GRID)) u_walk (
    .a         (wa),
    .b         (wb),
    .sa        (wsa),
    .sb        (wsb),
    .w         (ww),
    .h         (wh),
    .phase     (phase_r),
    .fwd       (fwd_r),
    .a_nxt     (wa_nxt),
    .b_nxt     (wb_nxt),
    .phase_nxt (phase_nxt),
    .fwd_nxt   (fwd_nxt),
    .more      (more)
  );

  always_comb begin
    sum_x = SW'(org_x_r) + SW'(prod_x_r);
    sum_y = SW'(org_y_r) + SW'(prod_y_r);
    out_nxt = '0;
    if (!cmd.zero) begin
      out_nxt.point_valid = 1'b1;
      out_nxt.col_index   = IDX_OUT_W'(walk_col_r);
      out_nxt.row_index   = IDX_OUT_W'(walk_row_r);
      out_nxt.point_x     = sat32(sum_x);
      out_nxt.point_y     = sat32(sum_y);
      out_nxt.last_point  = ~more;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= GRID_RST;
      grid_rows_r <= GRID_RST;
      org_x_r     <= '0;
      org_y_r     <= '0;
      step_x_r    <= STEP_RST;
      step_y_r    <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_COLUMNS: grid_cols_r <= cfg_data[6:0];
        CFG_GRID_ROWS:    grid_rows_r <= cfg_data[6:0];
        CFG_ORIGIN_X:     org_x_r     <= cfg_data;
        CFG_ORIGIN_Y:     org_y_r     <= cfg_data;
        CFG_STEP_X:       step_x_r    <= cfg_data[22:0];
        CFG_STEP_Y:       step_y_r    <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cols_mode_r <= 1'b0;
      start_col_r <= '0;
      start_row_r <= '0;
      walk_col_r  <= '0;
      walk_row_r  <= '0;
      phase_r     <= PH_LINE;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        cols_mode_r <= in_data.scan_by_columns;
      end
      if (cmd.seed) begin
        start_col_r <= qx;
        start_row_r <= qy;
        walk_col_r  <= qx;
        walk_row_r  <= qy;
        phase_r     <= PH_LINE;
        fwd_r       <= 1'b1;
        active_r    <= 1'b1;
      end
      if (cmd.emit && !cmd.zero) begin
        phase_r <= phase_nxt;
        fwd_r   <= fwd_nxt;
        if (cols_mode_r) begin
          walk_row_r <= wa_nxt;
          walk_col_r <= wb_nxt;
        end else begin
          walk_col_r <= wa_nxt;
          walk_row_r <= wb_nxt;
        end
        if (!more) begin
          active_r <= 1'b0;
        end
      end
      out_valid_r <= cmd.emit | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x_r <= PW'(walk_col_r) * PW'(sx);
      prod_y_r <= PW'(walk_row_r) * PW'(sy);
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign sts.active   = active_r;
  assign sts.div_done = x_done & y_done;
  assign sts.out_free = out_free;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// ===== rtl/core/spo_ctrl.sv =====
`timescale 1ns / 1ps
// spo_ctrl: sequencing state machine for the probe point sequencer.
// Depends on spo_pkg.
module spo_ctrl
  import spo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_stall,
  input  spo_sts_t sts,
  output spo_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       zero_r, zero_nxt;

  always_comb begin
    state_nxt = state_r;
    zero_nxt  = zero_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_START) begin
            cmd.start = 1'b1;
            zero_nxt  = 1'b0;
            state_nxt = S_DIV;
          end else if (sts.active) begin
            zero_nxt  = 1'b0;
            state_nxt = S_MUL;
          end else begin
            // request with no scan running: all-zero beat
            zero_nxt  = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.seed  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.zero = zero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      zero_r  <= zero_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

// ===== rtl/core/serpentine_probe_point_order.sv =====
`timescale 1ns / 1ps
// Serpentine probe point sequencer, top level. Depends on spo_pkg, spo_ctrl, spo_dp.
// Start beat: the bit-per-cycle rounding dividers find the nearest vertex, then the
//   index multiply and the saturating add form the point; a next-point beat takes
//   only the index multiply, then saturating add. The next beat is taken the cycle after
//   a result is loaded; the output register frees the input from a stalled output.
// Reset (synchronous, rst_n low): no scan active, configuration registers to their defaults.
module serpentine_probe_point_order
  import spo_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  spo_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spo_out_t              out_data
);

  spo_cmd_t cmd;
  spo_sts_t sts;

  spo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spo_dp #(.MAX_GRID(MAX_GRID)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/spo_checker.sv =====
`timescale 1ns / 1ps
// spo_checker: port-level assertions for the serpentine probe point sequencer,
// bound to the top level. Depends on spo_pkg.
module spo_checker
  import spo_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input spo_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous beat in work");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.point_valid |->
      out_data.col_index == '0 && out_data.row_index == '0 &&
      out_data.point_x == '0 && out_data.point_y == '0 && !out_data.last_point)
    else $error("empty result beat carries data");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_point |-> out_data.point_valid)
    else $error("last mark on an empty beat");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs active after reset");

endmodule

bind serpentine_probe_point_order spo_checker u_spo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
